// ----- hw/rtl/vooc_pkg.sv -----
// Shared types, constants and state encoding for the voxel occupancy counter.
package vooc_pkg;

    localparam int GRID_MAX   = 16;
    localparam int AXW        = $clog2(GRID_MAX);
    localparam int CELLS      = GRID_MAX * GRID_MAX * GRID_MAX;
    localparam int ADDRW      = 3 * AXW;
    localparam int QW         = 5;
    localparam int DW         = 33;
    localparam int OCCW       = 13;
    localparam int COLW       = 9;
    localparam int PCTW       = 15;
    localparam int CFGW       = 32;
    localparam int PCT_SCALE  = 25600;

    localparam logic [2:0] REG_GRID_CELLS = 3'd0;
    localparam logic [2:0] REG_MIN_X      = 3'd1;
    localparam logic [2:0] REG_MIN_Y      = 3'd2;
    localparam logic [2:0] REG_MIN_Z      = 3'd3;
    localparam logic [2:0] REG_MAX_X      = 3'd4;
    localparam logic [2:0] REG_MAX_Y      = 3'd5;
    localparam logic [2:0] REG_MAX_Z      = 3'd6;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
    } in_word_t;

    typedef struct packed {
        logic [OCCW-1:0] occupied_cells;
        logic [COLW-1:0] columns_along_z;
        logic [COLW-1:0] columns_along_y;
        logic [COLW-1:0] columns_along_x;
        logic [PCTW-1:0] pct_xy;
        logic [PCTW-1:0] pct_xz;
        logic [PCTW-1:0] pct_yz;
        logic [PCTW-1:0] pct_largest;
        logic [PCTW-1:0] pct_smallest;
        logic            grid_empty;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_AXIS,
        ST_DIV,
        ST_MARK,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_PCT,
        ST_PCT_DIV,
        ST_DONE
    } state_t;

endpackage

// ----- hw/rtl/vooc_divider.sv -----
// Shared restoring divider: one quotient bit per cycle.
module vooc_divider
    import vooc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW+QW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          busy,
    output logic [DW+QW-1:0] quotient
);
    localparam int NW = DW + QW;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg, quo_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [DW:0]   trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = '0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {rem_reg[DW-1:0], quo_reg[NW-1]};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
endmodule

// ----- hw/rtl/vooc_grid_mem.sv -----
// Occupancy bitmap memory, one write and one registered read port.
module vooc_grid_mem
    import vooc_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [ADDRW-1:0] waddr,
    input  logic             wdata,
    input  logic [ADDRW-1:0] raddr,
    output logic             rdata
);
    logic mem [CELLS];
    logic rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- hw/rtl/voxel_occupancy_occlusion_counter.sv -----
// Top level: voxel occupancy bitmap with insert and occlusion query sequencer.
// Reset starts a clearing pass over all 4096 cells (one cell per cycle); busy stays high meanwhile.
// Insert: one pass per axis through the shared 38-step serial divider, skipped for a clamped axis.
// Query: 3*q^3 bitmap reads (one read port, three passes) plus up to three divider passes.
// Result holds until the next query; done is high for one cycle; the receiver cannot stall.
// Configuration writes are taken at any time and hold their value until the next write.
module voxel_occupancy_occlusion_counter
    import vooc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  in_word_t        cmd,
    output logic            busy,
    output logic            done,
    output out_word_t       result,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  logic [CFGW-1:0] cfg_data
);
    localparam int NW  = DW + QW;

    // configuration
    logic [QW-1:0]      q_cfg_reg;
    logic signed [31:0] min_reg [3];
    logic signed [31:0] max_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_cfg_reg <= QW'(16);
            for (int i = 0; i < 3; i++)
            begin
                min_reg[i] <= '0;
                max_reg[i] <= 32'sd65536;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRID_CELLS: q_cfg_reg  <= cfg_data[QW-1:0];
                REG_MIN_X:      min_reg[0] <= cfg_data;
                REG_MIN_Y:      min_reg[1] <= cfg_data;
                REG_MIN_Z:      min_reg[2] <= cfg_data;
                REG_MAX_X:      max_reg[0] <= cfg_data;
                REG_MAX_Y:      max_reg[1] <= cfg_data;
                REG_MAX_Z:      max_reg[2] <= cfg_data;
                default:        ;
            endcase
        end
    end

    // effective grid size, clamped to 1..GRID_MAX
    logic [QW-1:0] q_eff;
    always_comb
    begin
        if (q_cfg_reg == '0)
            q_eff = QW'(1);
        else if (q_cfg_reg > QW'(GRID_MAX))
            q_eff = QW'(GRID_MAX);
        else
            q_eff = q_cfg_reg;
    end

    // sequencer state
    state_t state_reg, state_next;
    logic [1:0]       ax_reg, ax_next;
    logic [ADDRW:0]   clr_reg, clr_next;
    logic [AXW-1:0]   idx_reg [3];
    logic [AXW-1:0]   idx_next [3];
    logic signed [31:0] pt_reg [3];
    logic signed [31:0] pt_next [3];
    // scan counters: pass (0 z-cols,1 y-cols,2 x-cols), a, b, c
    logic [AXW:0]     a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic             any_reg, any_next;
    logic             rvalid_reg, rvalid_next;
    logic             rlast_reg, rlast_next;
    logic [OCCW-1:0]  occ_reg, occ_next;
    logic [COLW-1:0]  col_reg [3];
    logic [COLW-1:0]  col_next [3];
    logic [PCTW-1:0]  pct_reg [3];
    logic [PCTW-1:0]  pct_next [3];
    logic             done_reg, done_next;

    // per-axis differences for the divider
    logic signed [DW-1:0] dd, ee;
    always_comb
    begin
        dd = DW'(pt_reg[ax_reg]) - DW'(min_reg[ax_reg]);
        ee = DW'(max_reg[ax_reg]) - DW'(min_reg[ax_reg]);
    end

    // divider
    logic          div_start, div_busy;
    logic [NW-1:0] div_num, div_quo;
    logic [DW-1:0] div_den;

    vooc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // memory
    logic             mem_we, mem_wd, mem_rd;
    logic [ADDRW-1:0] mem_wa, mem_ra;

    vooc_grid_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_wa),
        .wdata (mem_wd),
        .raddr (mem_ra),
        .rdata (mem_rd)
    );

    // scan address: pass 0 -> (a,b,c); pass 1 -> (a,c,b); pass 2 -> (c,a,b)
    logic [AXW-1:0] sa, sb, sc;
    assign sa = a_reg[AXW-1:0];
    assign sb = b_reg[AXW-1:0];
    assign sc = c_reg[AXW-1:0];
    always_comb
    begin
        unique case (ax_reg)
            2'd0:    mem_ra = {sa, sb, sc};
            2'd1:    mem_ra = {sa, sc, sb};
            default: mem_ra = {sc, sa, sb};
        endcase
    end

    logic [OCCW-1:0] occ_diff;
    assign occ_diff = occ_reg - OCCW'(col_reg[ax_reg]);

    always_comb
    begin
        state_next  = state_reg;
        ax_next     = ax_reg;
        clr_next    = clr_reg;
        idx_next    = idx_reg;
        pt_next     = pt_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        any_next    = any_reg;
        rvalid_next = 1'b0;
        rlast_next  = 1'b0;
        occ_next    = occ_reg;
        col_next    = col_reg;
        pct_next    = pct_reg;
        done_next   = 1'b0;
        div_start   = 1'b0;
        div_num     = '0;
        div_den     = '0;
        mem_we      = 1'b0;
        mem_wa      = {idx_reg[0], idx_reg[1], idx_reg[2]};
        mem_wd      = 1'b1;

        // read data from a scan lands in the cycle after its address
        if (rvalid_reg)
        begin
            if (mem_rd)
            begin
                any_next = 1'b1;
                if (ax_reg == 2'd0)
                    occ_next = occ_reg + 1'b1;
            end
            if (rlast_reg)
            begin
                if (mem_rd || any_reg)
                    col_next[ax_reg] = col_reg[ax_reg] + 1'b1;
                any_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wd = 1'b0;
                mem_wa = clr_reg[ADDRW-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (ADDRW+1)'(CELLS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    pt_next[0] = cmd.coord_x;
                    pt_next[1] = cmd.coord_y;
                    pt_next[2] = cmd.coord_z;
                    ax_next    = 2'd0;
                    if (cmd.opcode == OP_INSERT)
                        state_next = ST_AXIS;
                    else
                    begin
                        a_next     = '0;
                        b_next     = '0;
                        c_next     = '0;
                        any_next   = 1'b0;
                        occ_next   = '0;
                        col_next   = '{default: '0};
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_AXIS:
            begin
                if (ee <= 0 || dd < 0)
                begin
                    idx_next[ax_reg] = '0;
                    state_next = (ax_reg == 2'd2) ? ST_MARK : ST_AXIS;
                    ax_next    = ax_reg + 1'b1;
                end
                else if (dd >= ee)
                begin
                    idx_next[ax_reg] = AXW'(q_eff - 1'b1);
                    state_next = (ax_reg == 2'd2) ? ST_MARK : ST_AXIS;
                    ax_next    = ax_reg + 1'b1;
                end
                else
                begin
                    // d * q by shift-add over the five bits of q
                    div_num = (NW'(dd) << 4) & {NW{q_eff[4]}};
                    div_num = div_num + ((NW'(dd) << 3) & {NW{q_eff[3]}});
                    div_num = div_num + ((NW'(dd) << 2) & {NW{q_eff[2]}});
                    div_num = div_num + ((NW'(dd) << 1) & {NW{q_eff[1]}});
                    div_num = div_num + (NW'(dd) & {NW{q_eff[0]}});
                    div_den   = ee;
                    div_start = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!div_busy)
                begin
                    idx_next[ax_reg] = div_quo[AXW-1:0];
                    state_next = (ax_reg == 2'd2) ? ST_MARK : ST_AXIS;
                    ax_next    = ax_reg + 1'b1;
                end
            end
            ST_MARK:
            begin
                mem_we     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                rvalid_next = 1'b1;
                rlast_next  = (c_reg == {1'b0, q_eff[AXW-1:0]} - 1'b1) ||
                              (c_reg == (AXW+1)'(q_eff) - 1'b1);
                if (c_reg == (AXW+1)'(q_eff) - 1'b1)
                begin
                    c_next = '0;
                    if (b_reg == (AXW+1)'(q_eff) - 1'b1)
                    begin
                        b_next = '0;
                        if (a_reg == (AXW+1)'(q_eff) - 1'b1)
                        begin
                            a_next     = '0;
                            state_next = ST_SCAN_WAIT;
                        end
                        else
                            a_next = a_reg + 1'b1;
                    end
                    else
                        b_next = b_reg + 1'b1;
                end
                else
                    c_next = c_reg + 1'b1;
            end
            ST_SCAN_WAIT:
            begin
                if (ax_reg == 2'd2)
                begin
                    ax_next    = 2'd0;
                    state_next = ST_PCT;
                end
                else
                begin
                    ax_next    = ax_reg + 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_PCT:
            begin
                if (occ_reg == '0)
                begin
                    pct_next[ax_reg] = '0;
                    ax_next    = ax_reg + 1'b1;
                    state_next = (ax_reg == 2'd2) ? ST_DONE : ST_PCT;
                end
                else
                begin
                    div_num   = NW'(occ_diff) * NW'(PCT_SCALE);
                    div_den   = DW'(occ_reg);
                    div_start = 1'b1;
                    state_next = ST_PCT_DIV;
                end
            end
            ST_PCT_DIV:
            begin
                if (!div_busy)
                begin
                    pct_next[ax_reg] = div_quo[PCTW-1:0];
                    ax_next    = ax_reg + 1'b1;
                    state_next = (ax_reg == 2'd2) ? ST_DONE : ST_PCT;
                end
            end
            ST_DONE:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            ax_reg     <= '0;
            clr_reg    <= '0;
            a_reg      <= '0;
            b_reg      <= '0;
            c_reg      <= '0;
            any_reg    <= 1'b0;
            rvalid_reg <= 1'b0;
            rlast_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ax_reg     <= ax_next;
            clr_reg    <= clr_next;
            a_reg      <= a_next;
            b_reg      <= b_next;
            c_reg      <= c_next;
            any_reg    <= any_next;
            rvalid_reg <= rvalid_next;
            rlast_reg  <= rlast_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        pt_reg  <= pt_next;
        occ_reg <= occ_next;
        col_reg <= col_next;
        pct_reg <= pct_next;
    end

    // result formatting; max/min over the three shares
    logic [PCTW-1:0] hi, lo;
    always_comb
    begin
        hi = pct_reg[0];
        lo = pct_reg[0];
        if (pct_reg[1] > hi) hi = pct_reg[1];
        if (pct_reg[2] > hi) hi = pct_reg[2];
        if (pct_reg[1] < lo) lo = pct_reg[1];
        if (pct_reg[2] < lo) lo = pct_reg[2];
        result.occupied_cells  = occ_reg;
        result.columns_along_z = col_reg[0];
        result.columns_along_y = col_reg[1];
        result.columns_along_x = col_reg[2];
        result.pct_xy          = pct_reg[0];
        result.pct_xz          = pct_reg[1];
        result.pct_yz          = pct_reg[2];
        result.pct_largest     = hi;
        result.pct_smallest    = lo;
        result.grid_empty      = (occ_reg == '0);
    end

    // ready again in the strobe cycle; a new word may be taken alongside the result
    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

`ifndef SYNTHESIS
    a_done_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == ST_DONE)
        else $error("result strobe without query completion");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_AXIS) |-> busy)
        else $error("busy low during work");
    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");
`endif
endmodule
